FILE: rtl/core/snrg_pkg.sv
// ----------------------------------------------------------------------------
// snrg_pkg: shared types and constants for the spectral noise gain block
// Holds the configuration bundle, the queue entry between the front and the
// back part, and the single-step square root and division helpers.
// ----------------------------------------------------------------------------
package snrg_pkg;

    // Default number of noise estimate entries.
    localparam int BIN_COUNT_DEF = 513;
    // Depth of the queue between the front and the back part.
    localparam int QUEUE_DEPTH = 32;
    // Square root: 32 result bits, two bits per stage.
    localparam int SQRT_STAGES = 16;
    // Division: 16 quotient bits, two bits per stage.
    localparam int DIV_STAGES = 8;

    // Unity gain in Q1.15.
    localparam logic [15:0] GAIN_ONE = 16'd32768;

    // Reset values of the configuration registers.
    localparam logic [15:0] ALPHA_RST = 16'd64225;
    localparam logic [15:0] BETA_RST = 16'd512;
    localparam logic [15:0] FLOOR_RST = 16'd328;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ALPHA = 2'd0;
    localparam logic [1:0] CFG_BETA = 2'd1;
    localparam logic [1:0] CFG_FLOOR = 2'd2;

    typedef struct packed {
        logic [15:0] alpha;
        logic [15:0] beta;
        logic [15:0] gfloor;
    } cfg_t;

    // One classified bin handed from the front to the back part.
    typedef struct packed {
        logic signed [23:0] re;
        logic signed [23:0] im;
        logic [31:0]        mag;
        logic [31:0]        noise;
        logic               unity;
    } qent_t;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
    } sqrt_t;

    typedef struct packed {
        logic [65:0] rem;
        logic [15:0] q;
    } div_t;

    // One digit of the bit-by-bit integer square root.
    function automatic sqrt_t sqrt_step(sqrt_t s, logic [1:0] pair);
        logic [35:0] cur;
        logic [35:0] trial;
        sqrt_t       r;
        cur   = {s.rem, pair};
        trial = {2'b00, s.root, 2'b01};
        if (cur >= trial) begin
            r.rem  = 34'(cur - trial);
            r.root = {s.root[30:0], 1'b1};
        end else begin
            r.rem  = cur[33:0];
            r.root = {s.root[30:0], 1'b0};
        end
        return r;
    endfunction

    // One quotient bit of the restoring division against a fixed divisor.
    function automatic div_t div_step(div_t s, logic [65:0] dsh);
        div_t r;
        if (s.rem >= dsh) begin
            r.rem = 66'((s.rem - dsh) << 1);
            r.q   = {s.q[14:0], 1'b1};
        end else begin
            r.rem = 66'(s.rem << 1);
            r.q   = {s.q[14:0], 1'b0};
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/snrg_ram.sv
// ----------------------------------------------------------------------------
// snrg_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered and returns
// the old contents on a read of the address being written.
// ----------------------------------------------------------------------------
module snrg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 513
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/snrg_front.sv
// ----------------------------------------------------------------------------
// snrg_front: magnitude and noise estimate front part
// Squares the bin, takes the square root over a pipeline, updates the bin's
// noise estimate in RAM with forwarding, and pushes the result to the queue.
// ----------------------------------------------------------------------------
module snrg_front #(
    parameter int BIN_COUNT = snrg_pkg::BIN_COUNT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_acc,
    input  logic [9:0]         in_idx,
    input  logic signed [23:0] in_re,
    input  logic signed [23:0] in_im,
    input  logic [15:0]        alpha,
    output logic               clr_busy,
    output logic               push,
    output snrg_pkg::qent_t    push_ent
);

    localparam int AW = $clog2(BIN_COUNT);
    localparam int NS = snrg_pkg::SQRT_STAGES;

    typedef struct packed {
        logic               vld;
        logic               inr;
        logic [9:0]         idx;
        logic signed [23:0] re;
        logic signed [23:0] im;
    } hdr_t;

    typedef struct packed {
        hdr_t            h;
        logic [63:0]     v;
        snrg_pkg::sqrt_t s;
    } sqst_t;

    hdr_t        p0_reg;
    hdr_t        p1_reg;
    hdr_t        p2_reg;
    logic [46:0] p1_sqa_reg;
    logic [46:0] p1_sqb_reg;
    logic [47:0] p2_sum_reg;
    sqst_t       stg_reg [NS];
    sqst_t       stg_next [NS];

    logic signed [47:0] pr_re;
    logic signed [47:0] pr_im;

    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          byp_hit_reg;
    logic [31:0]   byp_data_reg;
    logic          byp_hit_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [31:0]   ram_rdata;

    logic [31:0]        noise;
    logic signed [32:0] diff;
    logic [16:0]        wgt;
    logic signed [50:0] prod;
    logic signed [50:0] acc;
    logic [34:0]        acc_sh;
    logic [31:0]        acc_sat;
    logic               item_wr;

    // Input registers and squares of both parts.
    always_comb begin
        pr_re = p0_reg.re * p0_reg.re;
        pr_im = p0_reg.im * p0_reg.im;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_reg <= '0;
            p1_reg <= '0;
            p2_reg <= '0;
        end else begin
            p0_reg.vld <= in_acc;
            p0_reg.inr <= (32'(in_idx) < BIN_COUNT);
            p0_reg.idx <= in_idx;
            p0_reg.re  <= in_re;
            p0_reg.im  <= in_im;
            p1_reg     <= p0_reg;
            p2_reg     <= p1_reg;
        end
        p1_sqa_reg <= pr_re[46:0];
        p1_sqb_reg <= pr_im[46:0];
        p2_sum_reg <= {1'b0, p1_sqa_reg} + {1'b0, p1_sqb_reg};
    end

    // Square root pipeline: two result bits per stage.
    always_comb begin
        sqst_t cur;
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                cur.h = p2_reg;
                cur.v = {p2_sum_reg, 16'b0};
                cur.s = '0;
            end else begin
                cur = stg_reg[k-1];
            end
            stg_next[k].h = cur.h;
            stg_next[k].s = snrg_pkg::sqrt_step(snrg_pkg::sqrt_step(cur.s, cur.v[63:62]),
                                                cur.v[61:60]);
            stg_next[k].v = {cur.v[59:0], 4'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NS; k++) begin
                stg_reg[k] <= '0;
            end
        end else begin
            stg_reg <= stg_next;
        end
    end

    // Noise update: exponential average written as noise plus weighted difference.
    always_comb begin
        noise   = byp_hit_reg ? byp_data_reg : ram_rdata;
        diff    = $signed({1'b0, stg_reg[NS-1].s.root}) - $signed({1'b0, noise});
        wgt     = 17'h10000 - {1'b0, alpha};
        prod    = diff * $signed({1'b0, wgt});
        acc     = $signed({3'b000, noise, 16'b0}) + prod + 51'sd32768;
        acc_sh  = acc[50:16];
        acc_sat = (|acc_sh[34:32]) ? 32'hFFFF_FFFF : acc_sh[31:0];
        item_wr = stg_reg[NS-1].h.vld && stg_reg[NS-1].h.inr;
        byp_hit_next = item_wr && stg_reg[NS-2].h.vld
                    && (stg_reg[NS-2].h.idx == stg_reg[NS-1].h.idx);
    end

    // RAM port mux between the clearing pass and item updates.
    always_comb begin
        if (clr_busy_reg) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = item_wr;
            ram_waddr = AW'(stg_reg[NS-1].h.idx);
            ram_wdata = acc_sat;
        end
    end

    // Clearing pass and forwarding registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            byp_hit_reg  <= 1'b0;
        end else begin
            if (clr_busy_reg) begin
                if (clr_addr_reg == AW'(BIN_COUNT - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            byp_hit_reg <= byp_hit_next;
        end
        byp_data_reg <= acc_sat;
    end

    snrg_ram #(
        .WIDTH(32),
        .DEPTH(BIN_COUNT)
    ) u_noise_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (AW'(stg_reg[NS-2].h.idx)),
        .rd_data (ram_rdata)
    );

    // Result handed to the queue.
    always_comb begin
        push           = stg_reg[NS-1].h.vld;
        push_ent.re    = stg_reg[NS-1].h.re;
        push_ent.im    = stg_reg[NS-1].h.im;
        push_ent.mag   = stg_reg[NS-1].s.root;
        push_ent.noise = acc_sat;
        push_ent.unity = !stg_reg[NS-1].h.inr || (acc_sat == 32'd0);
    end

    assign clr_busy = clr_busy_reg;

endmodule

FILE: rtl/core/snrg_queue.sv
// ----------------------------------------------------------------------------
// snrg_queue: queue between the front and the back part
// A small register FIFO; the head entry is visible while the queue is not
// empty.
// ----------------------------------------------------------------------------
module snrg_queue #(
    parameter int DEPTH = snrg_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  snrg_pkg::qent_t push_ent,
    input  logic            pop,
    output logic            nempty,
    output logic            full,
    output snrg_pkg::qent_t head
);

    localparam int PW = $clog2(DEPTH);

    snrg_pkg::qent_t mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;

    // Storage write.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_ent;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    assign nempty = (count_reg != '0);
    assign full   = (count_reg == (PW+1)'(DEPTH));
    assign head   = mem_reg[rd_ptr_reg];

endmodule

FILE: rtl/core/snrg_back.sv
// ----------------------------------------------------------------------------
// snrg_back: gain and scaling back part
// Forms the gain mag / (mag + beta * noise) with a pipelined divider, applies
// the floor, scales the bin and holds the result in the output register.
// ----------------------------------------------------------------------------
module snrg_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  snrg_pkg::cfg_t     cfg,
    input  logic               q_nempty,
    input  snrg_pkg::qent_t    q_head,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [23:0] m_scaled_re,
    output logic signed [23:0] m_scaled_im,
    output logic [15:0]        m_applied_gain
);

    localparam int ND = snrg_pkg::DIV_STAGES;

    typedef struct packed {
        logic               vld;
        logic               unity;
        logic signed [23:0] re;
        logic signed [23:0] im;
    } bhdr_t;

    typedef struct packed {
        bhdr_t          h;
        logic [65:0]    dsh;
        snrg_pkg::div_t d;
    } dvst_t;

    logic en;

    bhdr_t       b0_h_reg;
    logic [31:0] b0_mag_reg;
    logic [31:0] b0_noise_reg;
    bhdr_t       b1_h_reg;
    logic [31:0] b1_mag_reg;
    logic [47:0] b1_prod_reg;
    bhdr_t       b2_h_reg;
    logic [39:0] b2_num_reg;
    logic [48:0] b2_den_reg;
    bhdr_t       b3_h_reg;
    logic [65:0] b3_n_reg;
    logic [65:0] b3_dsh_reg;
    dvst_t       dv_reg [ND];
    dvst_t       dv_next [ND];
    bhdr_t       g_h_reg;
    logic [15:0] g_gain_reg;
    bhdr_t       m_h_reg;
    logic [15:0] m_gain_reg;
    logic signed [40:0] m_pre_reg;
    logic signed [40:0] m_pim_reg;
    logic               out_vld_reg;
    logic signed [23:0] out_re_reg;
    logic signed [23:0] out_im_reg;
    logic [15:0]        out_gain_reg;

    logic [15:0]        qclip;
    logic [15:0]        fl;
    logic [15:0]        gain_next;
    logic signed [40:0] pre_next;
    logic signed [40:0] pim_next;
    logic signed [40:0] rre;
    logic signed [40:0] rim;

    // The whole back pipeline advances unless the output register is held.
    assign en    = !out_vld_reg || m_ready;
    assign q_pop = en && q_nempty;

    // Divider stages: two quotient bits each.
    always_comb begin
        dvst_t cur;
        for (int k = 0; k < ND; k++) begin
            if (k == 0) begin
                cur.h     = b3_h_reg;
                cur.dsh   = b3_dsh_reg;
                cur.d.rem = b3_n_reg;
                cur.d.q   = '0;
            end else begin
                cur = dv_reg[k-1];
            end
            dv_next[k].h   = cur.h;
            dv_next[k].dsh = cur.dsh;
            dv_next[k].d   = snrg_pkg::div_step(snrg_pkg::div_step(cur.d, cur.dsh), cur.dsh);
        end
    end

    // Gain clip, floor and unity override.
    always_comb begin
        qclip = (dv_reg[ND-1].d.q > snrg_pkg::GAIN_ONE) ? snrg_pkg::GAIN_ONE
                                                        : dv_reg[ND-1].d.q;
        fl    = (cfg.gfloor > snrg_pkg::GAIN_ONE) ? snrg_pkg::GAIN_ONE : cfg.gfloor;
        if (dv_reg[ND-1].h.unity) begin
            gain_next = snrg_pkg::GAIN_ONE;
        end else begin
            gain_next = (qclip < fl) ? fl : qclip;
        end
        pre_next = g_h_reg.re * $signed({1'b0, g_gain_reg});
        pim_next = g_h_reg.im * $signed({1'b0, g_gain_reg});
        rre      = m_pre_reg + 41'sd16384;
        rim      = m_pim_reg + 41'sd16384;
    end

    // Pipeline registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_h_reg    <= '0;
            b1_h_reg    <= '0;
            b2_h_reg    <= '0;
            b3_h_reg    <= '0;
            g_h_reg     <= '0;
            m_h_reg     <= '0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k < ND; k++) begin
                dv_reg[k] <= '0;
            end
        end else if (en) begin
            b0_h_reg.vld   <= q_nempty;
            b0_h_reg.unity <= q_head.unity;
            b0_h_reg.re    <= q_head.re;
            b0_h_reg.im    <= q_head.im;
            b0_mag_reg     <= q_head.mag;
            b0_noise_reg   <= q_head.noise;
            b1_h_reg       <= b0_h_reg;
            b1_mag_reg     <= b0_mag_reg;
            b1_prod_reg    <= cfg.beta * b0_noise_reg;
            b2_h_reg       <= b1_h_reg;
            b2_num_reg     <= {b1_mag_reg, 8'b0};
            b2_den_reg     <= {9'b0, b1_mag_reg, 8'b0} + {1'b0, b1_prod_reg};
            b3_h_reg       <= b2_h_reg;
            b3_n_reg       <= {11'b0, b2_num_reg, 15'b0} + {18'b0, b2_den_reg[48:1]};
            b3_dsh_reg     <= {2'b0, b2_den_reg, 15'b0};
            dv_reg         <= dv_next;
            g_h_reg        <= dv_reg[ND-1].h;
            g_gain_reg     <= gain_next;
            m_h_reg        <= g_h_reg;
            m_gain_reg     <= g_gain_reg;
            m_pre_reg      <= pre_next;
            m_pim_reg      <= pim_next;
            out_vld_reg    <= m_h_reg.vld;
            out_re_reg     <= rre[38:15];
            out_im_reg     <= rim[38:15];
            out_gain_reg   <= m_gain_reg;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_scaled_re    = out_re_reg;
    assign m_scaled_im    = out_im_reg;
    assign m_applied_gain = out_gain_reg;

endmodule

FILE: rtl/core/spectral_noise_gain_per_bin_top.sv
// ----------------------------------------------------------------------------
// spectral_noise_gain_per_bin_top: per-bin Wiener-style noise suppression gain
// Keeps a noise magnitude estimate per bin and returns each bin scaled by
// mag / (mag + beta * noise), held at or above a floor.
// ----------------------------------------------------------------------------
// The block takes one bin per clock cycle while s_ready is high and returns
// one result per bin, in order. The rate is set by the noise estimate RAM,
// which is read and written once per bin in an update with forwarding, so
// bins for the same index may follow back to back. s_ready is low while all
// queue credits are taken. The magnitude square root and the gain division
// are pipelined, two bits per stage. After reset a clearing pass zeroes all
// BIN_COUNT estimates, one entry a cycle; s_ready stays low during that pass.
// Configuration writes are taken at any time but belong to idle periods.
module spectral_noise_gain_per_bin_top #(
    parameter int BIN_COUNT = snrg_pkg::BIN_COUNT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [9:0]         s_bin_index,
    input  logic signed [23:0] s_bin_re,
    input  logic signed [23:0] s_bin_im,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [23:0] m_scaled_re,
    output logic signed [23:0] m_scaled_im,
    output logic [15:0]        m_applied_gain
);

    localparam int QD = snrg_pkg::QUEUE_DEPTH;
    localparam int CW = $clog2(QD + 1);

    snrg_pkg::cfg_t  cfg_reg;
    logic [CW-1:0]   credit_reg;
    logic            clr_busy;
    logic            in_acc;
    logic            push;
    snrg_pkg::qent_t push_ent;
    logic            q_pop;
    logic            q_nempty;
    logic            q_full;
    snrg_pkg::qent_t q_head;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alpha  <= snrg_pkg::ALPHA_RST;
            cfg_reg.beta   <= snrg_pkg::BETA_RST;
            cfg_reg.gfloor <= snrg_pkg::FLOOR_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                snrg_pkg::CFG_ALPHA: cfg_reg.alpha  <= cfg_wdata;
                snrg_pkg::CFG_BETA:  cfg_reg.beta   <= cfg_wdata;
                snrg_pkg::CFG_FLOOR: cfg_reg.gfloor <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Queue credits: bins taken that have not yet left the queue.
    assign s_ready = !clr_busy && (credit_reg < CW'(QD));
    assign in_acc  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
        end else begin
            credit_reg <= credit_reg + CW'(in_acc) - CW'(q_pop);
        end
    end

    snrg_front #(
        .BIN_COUNT(BIN_COUNT)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_acc   (in_acc),
        .in_idx   (s_bin_index),
        .in_re    (s_bin_re),
        .in_im    (s_bin_im),
        .alpha    (cfg_reg.alpha),
        .clr_busy (clr_busy),
        .push     (push),
        .push_ent (push_ent)
    );

    snrg_queue #(
        .DEPTH(QD)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_ent (push_ent),
        .pop      (q_pop),
        .nempty   (q_nempty),
        .full     (q_full),
        .head     (q_head)
    );

    snrg_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .q_nempty       (q_nempty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_scaled_re    (m_scaled_re),
        .m_scaled_im    (m_scaled_im),
        .m_applied_gain (m_applied_gain)
    );

    // Credits never exceed the queue depth.
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        credit_reg <= CW'(QD))
        else $error("credit count above queue depth");

    // No bin is taken during the clearing pass.
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_ready)
        else $error("bin accepted while clearing");

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!q_full || q_pop))
        else $error("queue overflow");

    // A pop always returns a credit that was taken.
    a_pop_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (credit_reg != '0))
        else $error("pop without credit");

endmodule
